/* sv/apostolico_giancarlo_matcher_top_defines.svh */
// Assertion macros shared by the matcher RTL.
// Used by files that carry concurrent checks; expects clk and rst in scope.
`ifndef APOSTOLICO_GIANCARLO_MATCHER_TOP_DEFINES_SVH
`define APOSTOLICO_GIANCARLO_MATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matcher check failed");
// next-cycle implication
`define AGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matcher check failed");
`else
`define AGM_ASSERT_IMP(lbl, ante, cons)
`define AGM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/agm_pkg.sv */
// Shared constants, controller commands and status bundle for the matcher.
// No dependencies.
package agm_pkg;

  localparam int MaxPattern = 64;
  localparam int PatAw      = $clog2(MaxPattern);
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int AlphAw     = 8;
  localparam int IdxW       = LenW + 1;
  localparam int ShW        = IdxW + 2;
  localparam int PosW       = 32;
  localparam int ByteW      = 8;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef logic signed [IdxW-1:0] idx_t;

  // controller state, also the command to the datapath
  typedef enum logic [21:0] {
    ST_IDLE       = 22'b1 << 0,
    ST_BC_INIT    = 22'b1 << 1,
    ST_BC_RD      = 22'b1 << 2,
    ST_BC_WR      = 22'b1 << 3,
    ST_SF_INIT    = 22'b1 << 4,
    ST_SF_TEST    = 22'b1 << 5,
    ST_SF_CMPK    = 22'b1 << 6,
    ST_SF_ELSE    = 22'b1 << 7,
    ST_SF_WRD     = 22'b1 << 8,
    ST_SF_WCMP    = 22'b1 << 9,
    ST_GS_INIT    = 22'b1 << 10,
    ST_GS1_RD     = 22'b1 << 11,
    ST_GS1_EV     = 22'b1 << 12,
    ST_GS1_FILL   = 22'b1 << 13,
    ST_GS2_RD     = 22'b1 << 14,
    ST_GS2_EV     = 22'b1 << 15,
    ST_BUILD_DONE = 22'b1 << 16,
    ST_CMP_RD     = 22'b1 << 17,
    ST_CMP_EV     = 22'b1 << 18,
    ST_FIN_RD     = 22'b1 << 19,
    ST_FIN_BC     = 22'b1 << 20,
    ST_FIN_EV     = 22'b1 << 21
  } agm_cmd_t;

  typedef struct packed {
    logic start_build;
    logic start_cmp;
    logic a8_last;
    logic m_one;
    logic m_lt2;
    logic bc_more;
    logic a_gt_lo;
    logic sf_copy;
    logic lo_ge0;
    logic p_eq;
    logic a_zero;
    logic gs_init_last;
    logic gs1_fill;
    logic gs1_more;
    logic gs2_last;
    logic cmp_done;
    logic out_busy;
  } agm_status_t;

endpackage

/* sv/agm_ctrl.sv */
// Controller state machine: table build, window compare and result hand-off.
// Depends on agm_pkg.
module agm_ctrl import agm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  agm_status_t st,
  output agm_cmd_t    cmd,
  output logic        in_ready
);

  agm_cmd_t state, state_next;

  assign cmd      = state;
  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (st.start_build) state_next = ST_BC_INIT;
        else if (st.start_cmp) state_next = ST_CMP_RD;
      end
      ST_BC_INIT: begin
        if (st.a8_last) state_next = st.m_one ? ST_SF_INIT : ST_BC_RD;
      end
      ST_BC_RD:   state_next = ST_BC_WR;
      ST_BC_WR:   state_next = st.bc_more ? ST_BC_RD : ST_SF_INIT;
      ST_SF_INIT: state_next = st.m_lt2 ? ST_GS_INIT : ST_SF_TEST;
      ST_SF_TEST: state_next = st.a_gt_lo ? ST_SF_CMPK : ST_SF_ELSE;
      ST_SF_CMPK: begin
        if (st.sf_copy) state_next = st.a_zero ? ST_GS_INIT : ST_SF_TEST;
        else state_next = ST_SF_ELSE;
      end
      ST_SF_ELSE: state_next = ST_SF_WRD;
      ST_SF_WRD: begin
        if (st.lo_ge0) state_next = ST_SF_WCMP;
        else state_next = st.a_zero ? ST_GS_INIT : ST_SF_TEST;
      end
      ST_SF_WCMP: begin
        if (st.p_eq) state_next = ST_SF_WRD;
        else state_next = st.a_zero ? ST_GS_INIT : ST_SF_TEST;
      end
      ST_GS_INIT: state_next = st.gs_init_last ? ST_GS1_RD : ST_GS_INIT;
      ST_GS1_RD:  state_next = ST_GS1_EV;
      ST_GS1_EV: begin
        if (st.gs1_fill) state_next = ST_GS1_FILL;
        else state_next = st.a_zero ? ST_GS2_RD : ST_GS1_RD;
      end
      ST_GS1_FILL: begin
        if (st.gs1_more) state_next = ST_GS1_FILL;
        else state_next = st.a_zero ? ST_GS2_RD : ST_GS1_RD;
      end
      ST_GS2_RD:     state_next = st.m_lt2 ? ST_BUILD_DONE : ST_GS2_EV;
      ST_GS2_EV:     state_next = st.gs2_last ? ST_BUILD_DONE : ST_GS2_RD;
      ST_BUILD_DONE: state_next = ST_IDLE;
      ST_CMP_RD:     state_next = ST_CMP_EV;
      ST_CMP_EV:     state_next = st.cmp_done ? ST_FIN_RD : ST_CMP_RD;
      ST_FIN_RD:     state_next = ST_FIN_BC;
      ST_FIN_BC:     state_next = ST_FIN_EV;
      ST_FIN_EV:     state_next = st.out_busy ? ST_FIN_EV : ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/agm_datapath.sv */
// Datapath: pattern, shift tables, skip table, text ring, positions, output.
// Depends on agm_pkg and the assertion macro header.
`include "apostolico_giancarlo_matcher_top_defines.svh"
module agm_datapath import agm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  agm_cmd_t          cmd,
  input  logic              in_valid,
  input  logic              opcode,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PosW-1:0]   match_position,
  output agm_status_t       st
);

  // control registers
  logic [LenW-1:0]       pat_len;
  logic                  loading;
  logic                  tables_ready;
  logic [PosW-1:0]       text_pos;
  logic [PosW-1:0]       win_start;
  logic [PatAw-1:0]      ring_head;
  logic [PatAw-1:0]      skip_base, skip_base_next;
  logic [MaxPattern-1:0] skip_valid, skip_valid_next;

  // loop registers
  idx_t                  a, lo, hi, idx;
  logic [LenW-1:0]       b;
  logic [AlphAw-1:0]     cnt8;
  logic                  last_q;
  logic [PosW-1:0]       cmp_start;

  // memories
  logic [ByteW-1:0]  pat_mem [MaxPattern];
  logic [LenW-1:0]   bc_mem  [2**AlphAw];
  logic [LenW-1:0]   sf_mem  [MaxPattern];
  logic [LenW-1:0]   gs_mem  [MaxPattern];
  logic [LenW-1:0]   sk_mem  [MaxPattern];
  logic [ByteW-1:0]  tw_mem  [MaxPattern];

  logic              pat_we;
  logic [PatAw-1:0]  pat_wa, pat_ra0, pat_ra1;
  logic              pat_re;
  logic [ByteW-1:0]  p_rd0, p_rd1;

  logic              bc_we, bc_re;
  logic [AlphAw-1:0] bc_wa, bc_ra;
  logic [LenW-1:0]   bc_wd, bc_rd;

  logic              sf_we, sf_re;
  logic [PatAw-1:0]  sf_wa, sf_ra;
  logic [LenW-1:0]   sf_wd, sf_rd;

  logic              gs_we, gs_re;
  logic [PatAw-1:0]  gs_wa, gs_ra;
  logic [LenW-1:0]   gs_wd, gs_rd;

  logic              sk_we, sk_re;
  logic [PatAw-1:0]  sk_wa, sk_ra;
  logic [LenW-1:0]   sk_wd, sk_rd;
  logic              sk_vld_rd;

  logic              tw_we, tw_re;
  logic [PatAw-1:0]  tw_ra;
  logic [ByteW-1:0]  tw_rd;

  // derived values
  logic              acc, acc_pat, acc_text, hit;
  logic [LenW-1:0]   eff_len;
  idx_t              mi, k_sf, pair_pos, slot_off;
  logic [PatAw-1:0]  slot;
  logic              match;
  logic              fin_ev_go, fin_now, fin_last, search_clear;
  logic [LenW-1:0]   k_val;
  idx_t              i_n;
  logic              done_n;
  logic signed [ShW-1:0] bc_s, gs_s, sh_s;
  logic [LenW-1:0]   sh;
  logic [LenW-1:0]   skip_val;

  assign acc      = in_valid && (cmd == ST_IDLE);
  assign acc_pat  = acc && (opcode == OP_PATTERN);
  assign acc_text = acc && (opcode == OP_TEXT);
  assign eff_len  = loading ? pat_len : '0;
  assign mi       = idx_t'({1'b0, pat_len});
  assign hit      = tables_ready && (pat_len != '0) &&
                    (text_pos == win_start + PosW'(pat_len) - PosW'(1));
  assign k_sf     = a + mi - idx_t'(1) - hi;
  assign pair_pos = lo + mi - idx_t'(1) - hi;
  assign slot_off = idx - mi + idx_t'(1);
  assign slot     = ring_head + slot_off[PatAw-1:0];
  assign match    = idx < 0;

  // one comparison step
  always_comb begin
    k_val  = sk_vld_rd ? sk_rd : '0;
    i_n    = idx;
    done_n = 1'b1;
    if (k_val != '0) begin
      if (k_val > sf_rd) begin
        if (idx + idx_t'(1) == idx_t'({1'b0, sf_rd})) i_n = -idx_t'(1);
        else i_n = idx - idx_t'({1'b0, sf_rd});
      end else begin
        i_n    = idx - idx_t'({1'b0, k_val});
        done_n = (k_val < sf_rd) || (i_n < 0);
      end
    end else if (p_rd0 == tw_rd) begin
      i_n    = idx - idx_t'(1);
      done_n = (i_n < 0);
    end
  end

  // window shift after a compare
  always_comb begin
    bc_s = $signed({{(ShW-LenW){1'b0}}, bc_rd}) - $signed({{(ShW-LenW){1'b0}}, pat_len})
           + ShW'(1) + ShW'(idx);
    gs_s = $signed({{(ShW-LenW){1'b0}}, gs_rd});
    sh_s = gs_s;
    if (!match && bc_s > gs_s) sh_s = bc_s;
    if (sh_s < ShW'(1)) sh_s = ShW'(1);
    sh       = sh_s[LenW-1:0];
    skip_val = match ? pat_len : LenW'(mi - idx_t'(1) - idx);
  end

  // status to controller
  always_comb begin
    st.start_build  = acc_pat && last;
    st.start_cmp    = acc_text && hit;
    st.a8_last      = (cnt8 == '1);
    st.m_one        = (pat_len == LenW'(1));
    st.m_lt2        = (pat_len < LenW'(2));
    st.bc_more      = (a + idx_t'(1) < mi - idx_t'(1));
    st.a_gt_lo      = (a > lo);
    st.sf_copy      = (idx_t'({1'b0, sf_rd}) < a - lo);
    st.lo_ge0       = (lo >= 0);
    st.p_eq         = (p_rd0 == p_rd1);
    st.a_zero       = (a == '0);
    st.gs_init_last = (a == mi - idx_t'(1));
    st.gs1_fill     = (idx_t'({1'b0, sf_rd}) == a + idx_t'(1)) &&
                      (idx_t'({1'b0, b}) < mi - idx_t'(1) - a);
    st.gs1_more     = (idx_t'({1'b0, b}) + idx_t'(1) < mi - idx_t'(1) - a);
    st.gs2_last     = (a == mi - idx_t'(2));
    st.cmp_done     = done_n;
    st.out_busy     = (cmd == ST_FIN_EV) && match && out_valid && !out_ready;
  end

  assign fin_ev_go    = (cmd == ST_FIN_EV) && !st.out_busy;
  assign fin_now      = (acc_text && !hit) || fin_ev_go;
  assign fin_last     = (cmd == ST_IDLE) ? last : last_q;
  assign search_clear = (fin_now && fin_last) || (cmd == ST_BUILD_DONE);

  // memory port steering
  always_comb begin
    pat_we = acc_pat && (eff_len < LenW'(MaxPattern));
    pat_wa = eff_len[PatAw-1:0];
    pat_re = 1'b0; pat_ra0 = '0; pat_ra1 = '0;
    bc_we = 1'b0; bc_wa = '0; bc_wd = '0; bc_re = 1'b0; bc_ra = tw_rd;
    sf_we = 1'b0; sf_wa = '0; sf_wd = '0; sf_re = 1'b0; sf_ra = '0;
    gs_we = 1'b0; gs_wa = '0; gs_wd = '0; gs_re = 1'b0;
    gs_ra = match ? '0 : idx[PatAw-1:0];
    sk_we = fin_ev_go && (sh < pat_len);
    sk_wa = skip_base + pat_len[PatAw-1:0] - PatAw'(1);
    sk_wd = skip_val;
    sk_re = 1'b0; sk_ra = skip_base + idx[PatAw-1:0];
    tw_we = acc_text; tw_re = 1'b0; tw_ra = slot;
    unique case (cmd)
      ST_BC_INIT: begin
        bc_we = 1'b1; bc_wa = cnt8; bc_wd = pat_len;
      end
      ST_BC_RD: begin
        pat_re = 1'b1; pat_ra0 = a[PatAw-1:0];
      end
      ST_BC_WR: begin
        bc_we = 1'b1; bc_wa = p_rd0; bc_wd = LenW'(mi - idx_t'(1) - a);
      end
      ST_SF_INIT: begin
        sf_we = 1'b1; sf_wa = PatAw'(pat_len - LenW'(1)); sf_wd = pat_len;
      end
      ST_SF_TEST: begin
        sf_re = 1'b1; sf_ra = k_sf[PatAw-1:0];
      end
      ST_SF_CMPK: begin
        sf_we = st.sf_copy; sf_wa = a[PatAw-1:0]; sf_wd = sf_rd;
      end
      ST_SF_WRD: begin
        pat_re = 1'b1; pat_ra0 = lo[PatAw-1:0]; pat_ra1 = pair_pos[PatAw-1:0];
        sf_we = !st.lo_ge0; sf_wa = a[PatAw-1:0]; sf_wd = LenW'(hi - lo);
      end
      ST_SF_WCMP: begin
        sf_we = !st.p_eq; sf_wa = a[PatAw-1:0]; sf_wd = LenW'(hi - lo);
      end
      ST_GS_INIT: begin
        gs_we = 1'b1; gs_wa = a[PatAw-1:0]; gs_wd = pat_len;
      end
      ST_GS1_RD, ST_GS2_RD: begin
        sf_re = 1'b1; sf_ra = a[PatAw-1:0];
      end
      ST_GS1_FILL: begin
        gs_we = 1'b1; gs_wa = b[PatAw-1:0]; gs_wd = LenW'(mi - idx_t'(1) - a);
      end
      ST_GS2_EV: begin
        gs_we = (sf_rd < pat_len);
        gs_wa = PatAw'(pat_len - LenW'(1) - sf_rd);
        gs_wd = LenW'(mi - idx_t'(1) - a);
      end
      ST_CMP_RD: begin
        pat_re = 1'b1; pat_ra0 = idx[PatAw-1:0];
        sf_re = 1'b1; sf_ra = idx[PatAw-1:0];
        sk_re = 1'b1; tw_re = 1'b1;
      end
      ST_FIN_RD: tw_re = 1'b1;
      ST_FIN_BC: begin
        bc_re = 1'b1; gs_re = 1'b1;
      end
      default: ;
    endcase
  end

  // memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_wa] <= data_byte;
    if (pat_re) begin
      p_rd0 <= pat_mem[pat_ra0];
      p_rd1 <= pat_mem[pat_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (bc_we) bc_mem[bc_wa] <= bc_wd;
    if (bc_re) bc_rd <= bc_mem[bc_ra];
  end

  always_ff @(posedge clk) begin
    if (sf_we) sf_mem[sf_wa] <= sf_wd;
    if (sf_re) sf_rd <= sf_mem[sf_ra];
  end

  always_ff @(posedge clk) begin
    if (gs_we) gs_mem[gs_wa] <= gs_wd;
    if (gs_re) gs_rd <= gs_mem[gs_ra];
  end

  always_ff @(posedge clk) begin
    if (sk_we) sk_mem[sk_wa] <= sk_wd;
    if (sk_re) begin
      sk_rd     <= sk_mem[sk_ra];
      sk_vld_rd <= skip_valid[sk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tw_we) tw_mem[ring_head] <= data_byte;
    if (tw_re) tw_rd <= tw_mem[tw_ra];
  end

  // skip table rotates by moving its base; entries rotating in are invalidated
  always_comb begin
    logic [PatAw-1:0] rel_pos;
    skip_valid_next = skip_valid;
    skip_base_next  = skip_base;
    rel_pos         = '0;
    if (fin_ev_go) begin
      if (sh < pat_len) begin
        skip_valid_next[sk_wa] = 1'b1;
        for (int p = 0; p < MaxPattern; p++) begin
          rel_pos = PatAw'(p) - skip_base - pat_len[PatAw-1:0];
          if ({1'b0, rel_pos} < sh) skip_valid_next[p] = 1'b0;
        end
        skip_base_next = skip_base + sh[PatAw-1:0];
      end else begin
        skip_valid_next = '0;
      end
    end
    if (search_clear) begin
      skip_valid_next = '0;
      skip_base_next  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len      <= '0;
      loading      <= 1'b0;
      tables_ready <= 1'b0;
      text_pos     <= '0;
      win_start    <= '0;
      ring_head    <= '0;
      skip_base    <= '0;
      skip_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      skip_valid <= skip_valid_next;
      skip_base  <= skip_base_next;
      if (acc_pat) begin
        if (!loading) tables_ready <= 1'b0;
        loading <= !last;
        pat_len <= (eff_len < LenW'(MaxPattern)) ? eff_len + LenW'(1) : eff_len;
      end
      if (cmd == ST_BUILD_DONE) tables_ready <= 1'b1;
      if (fin_ev_go) win_start <= win_start + PosW'(sh);
      if (fin_now) begin
        ring_head <= ring_head + PatAw'(1);
        text_pos  <= text_pos + PosW'(1);
      end
      if (search_clear) begin
        ring_head <= '0;
        text_pos  <= '0;
        win_start <= '0;
      end
      if (fin_ev_go && match) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // loop counters and payload
  always_ff @(posedge clk) begin
    if (fin_ev_go && match) match_position <= cmp_start;
    unique case (cmd)
      ST_IDLE: begin
        cnt8 <= '0;
        if (st.start_cmp) begin
          idx       <= mi - idx_t'(1);
          cmp_start <= win_start;
          last_q    <= last;
        end
      end
      ST_BC_INIT: begin
        cnt8 <= cnt8 + AlphAw'(1);
        if (st.a8_last) a <= '0;
      end
      ST_BC_WR: a <= a + idx_t'(1);
      ST_SF_INIT: begin
        lo <= mi - idx_t'(1);
        hi <= '0;
        a  <= st.m_lt2 ? idx_t'(0) : mi - idx_t'(2);
      end
      ST_SF_CMPK: if (st.sf_copy && !st.a_zero) a <= a - idx_t'(1);
      ST_SF_ELSE: begin
        if (a < lo) lo <= a;
        hi <= a;
      end
      ST_SF_WRD: if (!st.lo_ge0 && !st.a_zero) a <= a - idx_t'(1);
      ST_SF_WCMP: begin
        if (st.p_eq) lo <= lo - idx_t'(1);
        else if (!st.a_zero) a <= a - idx_t'(1);
      end
      ST_GS_INIT: begin
        if (st.gs_init_last) b <= '0;
        else a <= a + idx_t'(1);
      end
      ST_GS1_EV: if (!st.gs1_fill && !st.a_zero) a <= a - idx_t'(1);
      ST_GS1_FILL: begin
        b <= b + LenW'(1);
        if (!st.gs1_more && !st.a_zero) a <= a - idx_t'(1);
      end
      ST_GS2_EV: if (!st.gs2_last) a <= a + idx_t'(1);
      ST_CMP_EV: idx <= i_n;
      default: ;
    endcase
  end

  // checks
  `AGM_ASSERT_IMP(a_cmp_idx_live, cmd == ST_CMP_EV, idx >= 0)
  `AGM_ASSERT_IMP(a_wcmp_lo_live, cmd == ST_SF_WCMP, lo >= 0)
  `AGM_ASSERT_NEXT(a_match_out, fin_ev_go && match, out_valid && match_position == $past(cmp_start))
  `AGM_ASSERT_NEXT(a_build_clears, cmd == ST_BUILD_DONE, tables_ready && text_pos == '0 && skip_valid == '0)

endmodule

/* sv/apostolico_giancarlo_matcher_top.sv */
// Apostolico-Giancarlo byte matcher: pattern bytes are taken while idle; the last one
// starts the build of the bad-character, suffix and good-suffix tables.
// Text bytes are taken while idle; a byte that ends a window runs compare steps, each a
// read state and an evaluate state (skip, suffix, pattern and ring memories give one
// read each), then FIN_RD, FIN_BC and FIN_EV, where a match word is set valid.
// Synchronous active-high reset clears pattern length, positions and skip valid bits.
module apostolico_giancarlo_matcher_top import agm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PosW-1:0]   match_position
);

  agm_cmd_t    cmd;
  agm_status_t st;

  // sequencer
  agm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // tables, ring and positions
  agm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_valid       (in_valid),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_position (match_position),
    .st             (st)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for apostolico_giancarlo_matcher_top.
// Depends on agm_pkg; predicts match positions in-bench and checks every output word.
module tb_top;
  import agm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int LongHold   = 2000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            opcode = OP_PATTERN;
  logic [ByteW-1:0] data_byte = '0;
  logic            last = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [PosW-1:0] match_position;

  apostolico_giancarlo_matcher_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .match_position(match_position)
  );

  always #10 clk = ~clk;

  // matcher shadow state
  logic [7:0] pat_mem [MaxPattern];
  int unsigned pat_len;
  int bad_char [256];
  int suf_len [MaxPattern];
  int good_suf [MaxPattern];
  int skip_len [MaxPattern];
  logic [7:0] ring [MaxPattern];
  logic [31:0] text_pos, win_start;
  int unsigned ring_wr;
  bit loading, tables_ok;

  logic [31:0] pending_pos [$];
  int n_errors = 0;
  int n_words = 0;
  bit no_idle = 0;
  bit hold_long = 0;
  int quiet_cycles = 0;

  task automatic restart_text();
    for (int t = 0; t < MaxPattern; t++) skip_len[t] = 0;
    text_pos = 0;
    win_start = 0;
    ring_wr = 0;
  endtask

  task automatic build_shift_tables();
    int m, a, b, lo, hi, k;
    m = pat_len;
    for (a = 0; a < 256; a++) bad_char[a] = m;
    for (a = 0; a < m - 1; a++) bad_char[pat_mem[a]] = m - 1 - a;
    for (a = 0; a < MaxPattern; a++) suf_len[a] = 0;
    suf_len[m-1] = m;
    lo = m - 1;
    hi = 0;
    for (a = m - 2; a >= 0; a--) begin
      k = a + m - 1 - hi;
      if (a > lo && k >= 0 && k < m && suf_len[k] < a - lo) begin
        suf_len[a] = suf_len[k];
      end else begin
        if (a < lo) lo = a;
        hi = a;
        while (lo >= 0 && pat_mem[lo] == pat_mem[lo + m - 1 - hi]) lo--;
        suf_len[a] = hi - lo;
      end
    end
    for (a = 0; a < m; a++) good_suf[a] = m;
    b = 0;
    for (a = m - 1; a >= 0; a--) begin
      if (suf_len[a] == a + 1) begin
        for (; b < m - 1 - a; b++)
          if (good_suf[b] == m) good_suf[b] = m - 1 - a;
      end
    end
    for (a = 0; a <= m - 2; a++) begin
      k = m - 1 - suf_len[a];
      if (k >= 0 && k < m) good_suf[k] = m - 1 - a;
    end
    restart_text();
  endtask

  // right-to-left window compare with skip table; returns 1 on a full match
  function automatic bit compare_and_shift(int m, int unsigned cur);
    int i, k, s, sh, bc, t;
    int unsigned slot;
    i = m - 1;
    while (i >= 0) begin
      k = skip_len[i];
      s = suf_len[i];
      if (k > 0) begin
        if (k > s) begin
          if (i + 1 == s) i = -1;
          else i -= s;
          break;
        end
        i -= k;
        if (k < s) break;
      end else begin
        slot = (cur + MaxPattern - (m - 1 - i)) % MaxPattern;
        if (pat_mem[i] == ring[slot]) i--;
        else break;
      end
    end
    if (i < 0) begin
      skip_len[m-1] = m;
      sh = good_suf[0];
    end else begin
      skip_len[m-1] = m - 1 - i;
      slot = (cur + MaxPattern - (m - 1 - i)) % MaxPattern;
      bc = bad_char[ring[slot]] - m + 1 + i;
      sh = good_suf[i];
      if (bc > sh) sh = bc;
    end
    if (sh < 1) sh = 1;
    win_start += sh;
    if (sh < m) begin
      for (t = 0; t < m - sh; t++) skip_len[t] = skip_len[t + sh];
      for (t = m - sh; t < m; t++) skip_len[t] = 0;
    end else begin
      for (t = 0; t < MaxPattern; t++) skip_len[t] = 0;
    end
    return i < 0;
  endfunction

  task automatic predict_word(logic op, logic [7:0] b, logic lst);
    int unsigned m, cur;
    logic [31:0] st;
    if (op == OP_PATTERN) begin
      if (!loading) begin
        loading = 1;
        tables_ok = 0;
        pat_len = 0;
      end
      if (pat_len < MaxPattern) begin
        pat_mem[pat_len] = b;
        pat_len++;
      end
      if (lst) begin
        loading = 0;
        build_shift_tables();
        tables_ok = 1;
      end
    end else begin
      m = tables_ok ? pat_len : 0;
      cur = ring_wr;
      st = win_start;
      ring[cur] = b;
      if (m > 0 && text_pos == st + m - 1)
        if (compare_and_shift(m, cur)) pending_pos.push_back(st);
      ring_wr = (cur + 1) % MaxPattern;
      text_pos++;
      if (lst) restart_text();
    end
  endtask

  // send one word; valid stays up across back-to-back words
  task automatic send_word(logic op, logic [7:0] b, logic lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    last      <= lst;
    do @(posedge clk); while (!in_ready);
    predict_word(op, b, lst);
    n_words++;
  endtask

  task automatic send_bytes(logic op, logic [7:0] bytes [$]);
    for (int j = 0; j < bytes.size(); j++)
      send_word(op, bytes[j], j == bytes.size() - 1);
  endtask

  // output side: random stalls, one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        n = LongHold;
        hold_long = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each output word with the oldest expected position
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pos.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word: match_position=%0d", match_position);
      end else begin
        if (match_position !== pending_pos[0]) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected %0d, got %0d", pending_pos[0], match_position);
        end
        void'(pending_pos.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [7:0] q [$];
    // text with no pattern ever built
    q = '{8'h00, 8'hFF, 8'h5A};
    send_bytes(OP_TEXT, q);
    // one-byte and two-byte patterns at both byte extremes
    send_word(OP_PATTERN, 8'h00, 1'b1);
    q = '{8'h00, 8'hFF, 8'h00, 8'h00};
    send_bytes(OP_TEXT, q);
    q = '{8'hFF, 8'h00};
    send_bytes(OP_PATTERN, q);
    q = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send_bytes(OP_TEXT, q);
    // text arriving while a pattern is half loaded never matches
    send_word(OP_PATTERN, 8'h41, 1'b0);
    send_word(OP_TEXT, 8'h41, 1'b0);
    send_word(OP_TEXT, 8'h42, 1'b0);
    send_word(OP_PATTERN, 8'h42, 1'b1);
    q = '{8'h41, 8'h42, 8'h41, 8'h42};
    send_bytes(OP_TEXT, q);
    // overlong pattern: bytes past the store are dropped
    for (int j = 0; j < MaxPattern + 6; j++)
      send_word(OP_PATTERN, 8'h61, j == MaxPattern + 5);
    for (int j = 0; j < 2 * MaxPattern + 3; j++)
      send_word(OP_TEXT, (j == 70) ? 8'h62 : 8'h61, j == 2 * MaxPattern + 2);
  endtask

  task automatic test_backpressure();
    send_word(OP_PATTERN, 8'h41, 1'b1);
    hold_long = 1;
    for (int j = 0; j < 40; j++) send_word(OP_TEXT, 8'h41, j == 39);
  endtask

  task automatic test_random();
    logic [7:0] sym [4];
    logic [7:0] pat [$];
    int plen, tlen, nsym, r;
    logic [7:0] b;
    while (n_words < 1700) begin
      r = $urandom_range(0, 19);
      no_idle = (r == 0);
      if (r == 1) begin
        // noise: arbitrary opcodes and last marks
        repeat ($urandom_range(5, 30))
          send_word(logic'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        nsym = $urandom_range(1, 4);
        for (int j = 0; j < 4; j++) sym[j] = 8'($urandom);
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(9, MaxPattern)
                                            : $urandom_range(1, 8);
        pat.delete();
        for (int j = 0; j < plen; j++) pat.push_back(sym[$urandom_range(0, nsym - 1)]);
        send_bytes(OP_PATTERN, pat);
        tlen = $urandom_range(plen, plen + 60);
        for (int j = 0; j < tlen; j++) begin
          if ($urandom_range(0, 9) == 0 && j + plen <= tlen) begin
            for (int p = 0; p < plen; p++) send_word(OP_TEXT, pat[p], j + p == tlen - 1);
            j += plen - 1;
          end else begin
            b = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                             : sym[$urandom_range(0, nsym - 1)];
            send_word(OP_TEXT, b, j == tlen - 1);
          end
        end
      end
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    wait (pending_pos.size() == 0);
    repeat (300) @(posedge clk);
    if (n_errors == 0 && pending_pos.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/agm_pkg.sv
sv/agm_ctrl.sv
sv/agm_datapath.sv
sv/apostolico_giancarlo_matcher_top.sv
test/tb_top.sv
